FILE: hw/rtl/sp3d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp3d_pkg
// shared types and constants for the 3d sandpile topple engine
// ----------------------------------------------------------------------------
package sp3d_pkg;

  localparam int unsigned THRESH   = 6;
  localparam int unsigned EDGE_MAX = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TOPPLE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [2:0] cell_value;
  } in_req_t;

  typedef struct packed {
    logic [12:0] unstable_count;
    logic [16:0] grain_total;
    logic [14:0] lost_count;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINGLE_RD,
    ST_SINGLE_WR,
    ST_LIST_RD,
    ST_CENTRE_RD,
    ST_CENTRE_WR,
    ST_NB_RD,
    ST_NB_WR,
    ST_COPY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic start;
    logic single_rd;
    logic single_wr;
    logic list_rd;
    logic centre_rd;
    logic centre_wr;
    logic nb_rd;
    logic nb_wr;
    logic copy_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_topple;
    logic list_more;
    logic centre_ok;
    logic nb_last;
    logic copy_more;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sp3d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp3d_ctrl
// sequencer for clearing, single cell updates and topple generations
// ----------------------------------------------------------------------------
module sp3d_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_free,
  input  wire sp3d_pkg::sts_t  sts,
  output sp3d_pkg::cmd_t       cmd,
  output logic                 in_ready
);

  sp3d_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sp3d_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sp3d_pkg::ST_CLEAR:     if (sts.clear_last) state_nxt = sp3d_pkg::ST_IDLE;
      sp3d_pkg::ST_IDLE:      if (in_fire) begin
        state_nxt = sts.is_topple ? sp3d_pkg::ST_LIST_RD : sp3d_pkg::ST_SINGLE_RD;
      end
      sp3d_pkg::ST_SINGLE_RD: state_nxt = sp3d_pkg::ST_SINGLE_WR;
      sp3d_pkg::ST_SINGLE_WR: state_nxt = sp3d_pkg::ST_DONE;
      sp3d_pkg::ST_LIST_RD:   state_nxt = sts.list_more ? sp3d_pkg::ST_CENTRE_RD
                                                        : sp3d_pkg::ST_COPY;
      sp3d_pkg::ST_CENTRE_RD: state_nxt = sp3d_pkg::ST_CENTRE_WR;
      sp3d_pkg::ST_CENTRE_WR: state_nxt = sts.centre_ok ? sp3d_pkg::ST_NB_RD
                                                        : sp3d_pkg::ST_LIST_RD;
      sp3d_pkg::ST_NB_RD:     state_nxt = sp3d_pkg::ST_NB_WR;
      sp3d_pkg::ST_NB_WR:     state_nxt = sts.nb_last ? sp3d_pkg::ST_LIST_RD
                                                      : sp3d_pkg::ST_NB_RD;
      sp3d_pkg::ST_COPY:      if (!sts.copy_more) state_nxt = sp3d_pkg::ST_DONE;
      sp3d_pkg::ST_DONE:      if (out_free) state_nxt = sp3d_pkg::ST_IDLE;
      default:                state_nxt = sp3d_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sp3d_pkg::ST_CLEAR:     cmd.clear_step = 1'b1;
      sp3d_pkg::ST_IDLE:      begin
        in_ready = 1'b1;
        cmd.start = in_fire;
      end
      sp3d_pkg::ST_SINGLE_RD: cmd.single_rd = 1'b1;
      sp3d_pkg::ST_SINGLE_WR: cmd.single_wr = 1'b1;
      sp3d_pkg::ST_LIST_RD:   cmd.list_rd = 1'b1;
      sp3d_pkg::ST_CENTRE_RD: cmd.centre_rd = 1'b1;
      sp3d_pkg::ST_CENTRE_WR: cmd.centre_wr = 1'b1;
      sp3d_pkg::ST_NB_RD:     cmd.nb_rd = 1'b1;
      sp3d_pkg::ST_NB_WR:     cmd.nb_wr = 1'b1;
      sp3d_pkg::ST_COPY:      cmd.copy_step = 1'b1;
      sp3d_pkg::ST_DONE:      cmd.finish = out_free;
      default:                cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sp3d_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp3d_dp
// grid memory, two site lists, counters and neighbour address unit
// ----------------------------------------------------------------------------
module sp3d_dp #(
  parameter int unsigned COUNT_BITS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sp3d_pkg::cmd_t    cmd,
  input  wire sp3d_pkg::in_req_t in_req,
  input  wire logic [4:0]        edge_cfg,
  output sp3d_pkg::sts_t         sts,
  output sp3d_pkg::out_req_t     res
);

  localparam int unsigned EDGE_MAX = sp3d_pkg::EDGE_MAX;
  localparam int unsigned CB    = $clog2(EDGE_MAX);
  localparam int unsigned IB    = 3 * CB;
  localparam int unsigned CELLS = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam int unsigned LB    = IB + 1;
  localparam int unsigned EB    = CB + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] TH   = COUNT_BITS'(sp3d_pkg::THRESH);

  logic [COUNT_BITS-1:0] grid_mem [CELLS];
  logic [IB-1:0]         cur_mem  [CELLS];
  logic [IB-1:0]         nxt_mem  [CELLS];

  logic [COUNT_BITS-1:0] grid_q_r;
  logic [IB-1:0]         cur_q_r, nxt_q_r;

  logic [LB-1:0] cur_len_r, cur_len_nxt, nxt_len_r, nxt_len_nxt;
  logic [LB-1:0] ptr_r, ptr_nxt;
  logic [16:0]   total_r, total_nxt;
  logic [14:0]   lost_r, lost_nxt;
  logic [IB-1:0] clr_r, clr_nxt;
  logic [2:0]    nb_r, nb_nxt;
  logic          copy_pend_r, copy_pend_nxt;
  sp3d_pkg::in_req_t req_r;
  logic [CB-1:0] sx_r, sy_r, sz_r;
  logic [IB-1:0] nb_idx_r, nb_idx_nxt;
  logic          nb_in_r, nb_in_nxt;
  logic [1:0]    op_r;

  logic [EB-1:0] edge_e;
  always_comb begin
    if (edge_cfg < 5'd2) edge_e = EB'(2);
    else if (32'(edge_cfg) > EDGE_MAX) edge_e = EB'(EDGE_MAX);
    else edge_e = EB'(edge_cfg);
  end

  logic [CB-1:0] px, py, pz;
  logic          p_in;
  logic [IB-1:0] p_idx;
  assign px = req_r.pos_x[CB-1:0];
  assign py = req_r.pos_y[CB-1:0];
  assign pz = req_r.pos_z[CB-1:0];
  assign p_in = ({1'b0, req_r.pos_x} < 5'(edge_e)) && ({1'b0, req_r.pos_y} < 5'(edge_e))
             && ({1'b0, req_r.pos_z} < 5'(edge_e));
  assign p_idx = {px, py, pz};

  logic [CB-1:0] lx, ly, lz;
  assign lx = cur_q_r[IB-1 -: CB];
  assign ly = cur_q_r[2*CB-1 -: CB];
  assign lz = cur_q_r[CB-1:0];

  // neighbour of the held site for the next step number
  logic [EB-1:0] ax, ay, az, v;
  logic          up, ok;
  logic [1:0]    axis;
  always_comb begin
    axis = nb_nxt[2:1];
    up   = ~nb_nxt[0];
    ax = {1'b0, sx_r}; ay = {1'b0, sy_r}; az = {1'b0, sz_r};
    v = (axis == 2'd0) ? ax : (axis == 2'd1) ? ay : az;
    ok = up ? (v + EB'(1) < edge_e) : (v != '0);
    v  = up ? v + EB'(1) : v - EB'(1);
    if (axis == 2'd0) ax = v; else if (axis == 2'd1) ay = v; else az = v;
    nb_in_nxt  = ok;
    nb_idx_nxt = {ax[CB-1:0], ay[CB-1:0], az[CB-1:0]};
  end

  logic [COUNT_BITS-1:0] wval;
  logic                  wen, list_add;
  logic [IB-1:0]         waddr;

  always_comb begin
    cur_len_nxt = cur_len_r; nxt_len_nxt = nxt_len_r; ptr_nxt = ptr_r;
    total_nxt = total_r; lost_nxt = lost_r; clr_nxt = clr_r; nb_nxt = nb_r;
    copy_pend_nxt = copy_pend_r;
    wen = 1'b0; waddr = p_idx; wval = '0; list_add = 1'b0;
    if (cmd.clear_step) begin
      wen = 1'b1; waddr = clr_r; clr_nxt = clr_r + IB'(1);
    end
    if (cmd.start) begin
      lost_nxt = '0; ptr_nxt = '0; nxt_len_nxt = '0;
    end
    if (cmd.single_wr && p_in) begin
      if (op_r == sp3d_pkg::OP_ADD) begin
        if (grid_q_r == CMAX) lost_nxt = 15'd1;
        else begin
          wen = 1'b1; wval = grid_q_r + COUNT_BITS'(1);
          total_nxt = total_r + 17'd1;
          if (wval == TH && 32'(cur_len_r) < CELLS) begin
            list_add = 1'b1; cur_len_nxt = cur_len_r + LB'(1);
          end
        end
      end else if (op_r == sp3d_pkg::OP_WRITE) begin
        wen = 1'b1; wval = COUNT_BITS'(req_r.cell_value > 3'd5 ? 3'd5 : req_r.cell_value);
        total_nxt = total_r - 17'(grid_q_r) + 17'(wval);
      end
    end
    if (cmd.list_rd) ptr_nxt = ptr_r + LB'(1);
    if (cmd.centre_wr && sts.centre_ok) begin
      wen = 1'b1; waddr = {sx_r, sy_r, sz_r}; wval = grid_q_r - TH;
      total_nxt = total_r - 17'(sp3d_pkg::THRESH);
      nb_nxt = '0;
    end
    if (cmd.nb_wr) begin
      nb_nxt = nb_r + 3'd1;
      waddr = nb_idx_r;
      if (!nb_in_r || grid_q_r == CMAX) lost_nxt = lost_r + 15'd1;
      else begin
        wen = 1'b1; wval = grid_q_r + COUNT_BITS'(1);
        total_nxt = total_r + 17'd1;
        if (wval == TH && 32'(nxt_len_r) < CELLS) begin
          list_add = 1'b1; nxt_len_nxt = nxt_len_r + LB'(1);
        end
      end
    end
    if (cmd.list_rd && !sts.list_more) begin
      ptr_nxt = '0; copy_pend_nxt = 1'b0;
    end
    if (cmd.copy_step) begin
      copy_pend_nxt = 1'b1;
      ptr_nxt = ptr_r + LB'(1);
      if (!sts.copy_more) cur_len_nxt = nxt_len_r;
    end
  end

  logic          copy_wr;
  logic [LB-1:0] copy_at;
  always_ff @(posedge clk) begin
    if (wen) grid_mem[waddr] <= wval;
    grid_q_r <= grid_mem[cmd.nb_rd ? nb_idx_r : (cmd.centre_rd ? cur_q_r : p_idx)];
    cur_q_r  <= cur_mem[ptr_r[IB-1:0]];
    nxt_q_r  <= nxt_mem[ptr_r[IB-1:0]];
    if (list_add && cmd.single_wr) cur_mem[cur_len_r[IB-1:0]] <= p_idx;
    if (list_add && cmd.nb_wr) nxt_mem[nxt_len_r[IB-1:0]] <= nb_idx_r;
    if (copy_wr) cur_mem[copy_at[IB-1:0]] <= nxt_q_r;
  end

  // copy reads are registered; write the previous address
  logic [LB-1:0] copy_at_r;
  assign copy_at = copy_at_r;
  assign copy_wr = cmd.copy_step && copy_pend_r;

  always_ff @(posedge clk) begin
    if (cmd.start) req_r <= in_req;
    if (cmd.start) op_r <= in_req.opcode;
    if (cmd.centre_rd) begin
      sx_r <= lx; sy_r <= ly; sz_r <= lz;
    end
    if (cmd.centre_wr || cmd.nb_wr) begin
      nb_idx_r <= nb_idx_nxt; nb_in_r <= nb_in_nxt;
    end
    copy_at_r <= ptr_r;
    if (!rst_n) begin
      cur_len_r <= '0; nxt_len_r <= '0; ptr_r <= '0; total_r <= '0; lost_r <= '0;
      clr_r <= '0; nb_r <= '0; copy_pend_r <= 1'b0;
    end else begin
      cur_len_r <= cur_len_nxt; nxt_len_r <= nxt_len_nxt; ptr_r <= ptr_nxt;
      total_r <= total_nxt; lost_r <= lost_nxt; clr_r <= clr_nxt; nb_r <= nb_nxt;
      copy_pend_r <= copy_pend_nxt;
    end
  end

  logic c_in;
  assign c_in = ({1'b0, lx} < edge_e) && ({1'b0, ly} < edge_e) && ({1'b0, lz} < edge_e);
  logic c_in_r;
  always_ff @(posedge clk) if (cmd.centre_rd) c_in_r <= c_in;

  always_comb begin
    sts.clear_last = (clr_r == IB'(CELLS - 1));
    sts.is_topple  = (in_req.opcode == sp3d_pkg::OP_TOPPLE);
    sts.list_more  = (ptr_r < cur_len_r);
    sts.centre_ok  = c_in_r && (grid_q_r >= TH);
    sts.nb_last    = (nb_r == 3'd5);
    sts.copy_more  = (ptr_r <= nxt_len_r) && (nxt_len_r != '0);
    res.unstable_count = 13'(cur_len_r);
    res.grain_total    = total_r;
    res.lost_count     = lost_r;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sandpile_3d_topple_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sandpile_3d_topple_engine
// 3d sandpile with threshold six: cell writes, grain adds, topple generations
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in_      in   in_valid/in_ready  sp3d_pkg::in_req_t
// out_     out  out_valid/out_ready sp3d_pkg::out_req_t
// cfg_     in   apb, pready high   edge_length at 0
// add or write: read and write one cell; topple: read each listed site, update each
// site that topples and its six neighbours, then copy the next list; all grid
// access goes through the single grid port
// after reset a clearing pass over all EDGE_MAX^3 cells holds in_ready low
// one item at a time; a finished result waits in the output register
module sandpile_3d_topple_engine #(
  parameter int unsigned COUNT_BITS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sp3d_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sp3d_pkg::out_req_t      out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  sp3d_pkg::cmd_t     cmd;
  sp3d_pkg::sts_t     sts;
  sp3d_pkg::out_req_t res;
  logic [4:0]         edge_r;
  logic               out_valid_r;
  logic               in_fire;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) edge_r <= 5'd16;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      edge_r <= cfg_pwdata[4:0];
  end
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {27'd0, edge_r} : 32'd0;

  assign in_fire = in_valid && in_ready;

  sp3d_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(!out_valid_r || out_ready), .sts(sts), .cmd(cmd), .in_ready(in_ready)
  );

  sp3d_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_req(in_data), .edge_cfg(edge_r),
    .sts(sts), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (cmd.finish) out_data <= res;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/sp3d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp3d_port_props
// port level checks for the topple engine
// ----------------------------------------------------------------------------
module sp3d_port_props (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sp3d_pkg::out_req_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy accept");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("reset out");

endmodule

bind sandpile_3d_topple_engine sp3d_port_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

FILE: tb/sv/sp3d_checker.sv
// ----------------------------------------------------------------------------
// sp3d_checker
// watches the request channels and the register port of the sandpile engine,
// keeps its own copy of the grid and lists, and compares every result request
// field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module sp3d_checker #(
  parameter int unsigned EDGE_MAX   = 16,
  parameter int unsigned COUNT_BITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sp3d_pkg::in_req_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sp3d_pkg::out_req_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int CELLS     = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam int COUNT_TOP = (1 << COUNT_BITS) - 1;
  localparam logic [1:0] ADDR_EDGE = 2'd0;

  logic [COUNT_BITS-1:0] grid [CELLS];
  int       live_sites [CELLS];
  int       next_sites [CELLS];
  int       live_len;
  int       next_len;
  int       grain_sum;
  logic [4:0] edge_reg;
  sp3d_pkg::out_req_t result_q [$];
  int       fails;

  function automatic int edge_in_use();
    if (edge_reg < 2) return 2;
    if (edge_reg > EDGE_MAX) return EDGE_MAX;
    return edge_reg;
  endfunction

  function automatic int site_index(int x, int y, int z);
    return (x * EDGE_MAX + y) * EDGE_MAX + z;
  endfunction

  task automatic drop_grain(int idx, bit to_next, output int lost);
    int c;
    c = grid[idx];
    lost = 0;
    if (c >= COUNT_TOP) begin
      lost = 1;
    end else begin
      grid[idx] = COUNT_BITS'(c + 1);
      grain_sum++;
      if (c + 1 == sp3d_pkg::THRESH) begin
        if (to_next) begin
          if (next_len < CELLS) begin
            next_sites[next_len] = idx;
            next_len++;
          end
        end else if (live_len < CELLS) begin
          live_sites[live_len] = idx;
          live_len++;
        end
      end
    end
  endtask

  task automatic topple_generation(output int lost);
    int e, n, idx, x, y, z, nx, ny, nz, d, lb;
    e = edge_in_use();
    lost = 0;
    next_len = 0;
    for (n = 0; n < live_len; n++) begin
      idx = live_sites[n] % CELLS;
      x = idx / (EDGE_MAX * EDGE_MAX);
      y = (idx / EDGE_MAX) % EDGE_MAX;
      z = idx % EDGE_MAX;
      if (x >= e || y >= e || z >= e) continue;
      if (grid[idx] < sp3d_pkg::THRESH) continue;
      grid[idx] = grid[idx] - COUNT_BITS'(sp3d_pkg::THRESH);
      grain_sum -= sp3d_pkg::THRESH;
      for (d = 0; d < 6; d++) begin
        nx = x; ny = y; nz = z;
        case (d)
          0: nx = x + 1;
          1: nx = x - 1;
          2: ny = y + 1;
          3: ny = y - 1;
          4: nz = z + 1;
          default: nz = z - 1;
        endcase
        if (nx < 0 || ny < 0 || nz < 0 || nx >= e || ny >= e || nz >= e) begin
          lost++;
        end else begin
          drop_grain(site_index(nx, ny, nz), 1'b1, lb);
          lost += lb;
        end
      end
    end
    for (n = 0; n < next_len; n++) live_sites[n] = next_sites[n];
    live_len = next_len;
  endtask

  task automatic predict_counts(sp3d_pkg::in_req_t r, output sp3d_pkg::out_req_t o);
    int e, idx, lost, v;
    bit in_cube;
    e = edge_in_use();
    lost = 0;
    in_cube = r.pos_x < e && r.pos_y < e && r.pos_z < e;
    idx = site_index(r.pos_x, r.pos_y, r.pos_z);
    case (sp3d_pkg::opcode_t'(r.opcode))
      sp3d_pkg::OP_ADD: begin
        if (in_cube) drop_grain(idx, 1'b0, lost);
      end
      sp3d_pkg::OP_TOPPLE: begin
        topple_generation(lost);
      end
      sp3d_pkg::OP_WRITE: begin
        if (in_cube) begin
          v = r.cell_value;
          if (v > 5) v = 5;
          if (v > COUNT_TOP) v = COUNT_TOP;
          grain_sum = grain_sum - grid[idx] + v;
          grid[idx] = COUNT_BITS'(v);
        end
      end
      default: ;
    endcase
    o.unstable_count = 13'(live_len);
    o.grain_total    = 17'(grain_sum);
    o.lost_count     = 15'(lost);
  endtask

  always @(posedge clk) begin
    sp3d_pkg::out_req_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) grid[i] = '0;
      live_len  = 0;
      next_len  = 0;
      grain_sum = 0;
      edge_reg  = 5'd16;
      result_q.delete();
      fails = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result request %h", out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: count %0d/%0d total %0d/%0d lost %0d/%0d (exp/act)",
                       want.unstable_count, out_data.unstable_count,
                       want.grain_total, out_data.grain_total,
                       want.lost_count, out_data.lost_count);
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_EDGE)
        edge_reg = cfg_pwdata[4:0];
      if (in_valid && in_ready) begin
        predict_counts(in_data, want);
        result_q.push_back(want);
      end
    end
    fail_count    <= fails;
    pending_count <= result_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the 3d sandpile engine: directed corner cases, then random
// fills, grain drops and topple generations over several cube sizes, with
// bursty requests and a stalling receiver; the checker gives the verdict
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ADDR_EDGE = 2'd0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sp3d_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sp3d_pkg::out_req_t out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [1:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count;
  int                 pending_count;
  int                 hold_req = 0;
  int                 edge_now = 16;
  int                 burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sandpile_3d_topple_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  sp3d_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver: changing stall modes, plus a long hold when asked
  initial begin
    int mode, mode_left, hold_left, seen_hold;
    mode = 0; mode_left = 0; hold_left = 0; seen_hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_hold) begin
        seen_hold = hold_req;
        hold_left = 600;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send(sp3d_pkg::in_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(sp3d_pkg::opcode_t op, int x, int y, int z, int v);
    sp3d_pkg::in_req_t r;
    r.opcode = op;
    r.pos_x = 4'(x);
    r.pos_y = 4'(y);
    r.pos_z = 4'(z);
    r.cell_value = 3'(v);
    send(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_edge(int val);
    drain();
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_EDGE; cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
    edge_now = val < 2 ? 2 : (val > 16 ? 16 : val);
  endtask

  function automatic int coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, edge_now - 1);
  endfunction

  task automatic random_item();
    int sel, v;
    sel = $urandom_range(0, 99);
    v = ($urandom_range(0, 1) == 1) ? 5 : $urandom_range(0, 7);
    if (sel < 40)      send_op(sp3d_pkg::OP_ADD, coord(), coord(), coord(),
                               $urandom_range(0, 7));
    else if (sel < 70) send_op(sp3d_pkg::OP_TOPPLE, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 7));
    else if (sel < 95) send_op(sp3d_pkg::OP_WRITE, coord(), coord(), coord(), v);
    else               send_op(sp3d_pkg::OP_NOP, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 7));
  endtask

  initial begin
    int edges [10];
    edges = '{2, 3, 4, 5, 8, 0, 1, 31, 16, 3};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_edge(16);

    // directed corners
    send_op(sp3d_pkg::OP_WRITE, 0, 0, 0, 5);
    send_op(sp3d_pkg::OP_ADD, 0, 0, 0, 0);
    send_op(sp3d_pkg::OP_TOPPLE, 0, 0, 0, 0);
    send_op(sp3d_pkg::OP_NOP, 15, 15, 15, 7);
    send_op(sp3d_pkg::OP_WRITE, 15, 15, 15, 7);
    send_op(sp3d_pkg::OP_ADD, 15, 15, 15, 0);
    send_op(sp3d_pkg::OP_WRITE, 15, 15, 15, 0);
    send_op(sp3d_pkg::OP_TOPPLE, 0, 0, 0, 0);
    send_op(sp3d_pkg::OP_WRITE, 5, 5, 5, 6);
    repeat (27) send_op(sp3d_pkg::OP_ADD, 5, 5, 5, 0);
    send_op(sp3d_pkg::OP_WRITE, 10, 10, 10, 5);
    send_op(sp3d_pkg::OP_ADD, 10, 10, 10, 0);
    set_edge(4);
    send_op(sp3d_pkg::OP_TOPPLE, 0, 0, 0, 0);
    send_op(sp3d_pkg::OP_ADD, 10, 10, 10, 0);
    send_op(sp3d_pkg::OP_WRITE, 3, 15, 0, 5);

    for (int p = 0; p < 10; p++) begin
      set_edge(edges[p]);
      for (int i = 0; i < 150; i++) begin
        if (p == 1 && i == 40) hold_req++;
        if (p == 2 && i == 75) drain();
        random_item();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #240000000;
    $display("FAILURE");
    $finish;
  end

endmodule
